// ----- src/sos_pkg.sv -----
// ----------------------------------------------------------------------------
// sos_pkg: shared types and constants for the set-of-stacks unit
// Store sizing, field widths, operation and status codes, and the per-cell
// control word.
// ----------------------------------------------------------------------------
package sos_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 7;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 6;
    localparam int STAT_W  = 2;
    localparam int USE_W   = 7;
    localparam int PROD_W  = IDX_W + 1 + SIZE_W;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

    // Register index taken from paddr[2]
    localparam logic REG_SUBSTACK_SIZE = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_POP_AT = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_NO_SUB = 2'd3
    } stat_t;

    // Control word broadcast along the cell row
    typedef struct packed {
        logic              push;
        logic              remove;
        logic [ADDR_W-1:0] pos;
    } op_t;

endpackage

// ----- src/sos_cell.sv -----
// ----------------------------------------------------------------------------
// sos_cell: one word of the packed store
// Loads the pushed word at its own position, or takes its upper neighbor's
// word when a removal at or below it closes the gap.
// ----------------------------------------------------------------------------
module sos_cell (
    input  logic                        aclk,
    input  logic [sos_pkg::ADDR_W-1:0]  cell_idx,
    input  sos_pkg::op_t                op,
    input  logic [sos_pkg::DATA_W-1:0]  push_word,
    input  logic [sos_pkg::DATA_W-1:0]  upper_word,
    output logic [sos_pkg::DATA_W-1:0]  word
);
    import sos_pkg::*;

    logic [DATA_W-1:0] word_reg;

    always_ff @(posedge aclk) begin
        if (op.push && (op.pos == cell_idx)) begin
            word_reg <= push_word;
        end else if (op.remove && (cell_idx >= op.pos)) begin
            word_reg <= upper_word;
        end
    end

    assign word = word_reg;

endmodule

// ----- src/sos_ctrl.sv -----
// ----------------------------------------------------------------------------
// sos_ctrl: operation decode, counters and result register
// Tracks word count, substacks in use and the fill of the last substack,
// drives the cell row and recounts substacks after a size change.
// ----------------------------------------------------------------------------
module sos_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sos_pkg::KIND_W-1:0]   s_kind,
    input  logic [sos_pkg::IDX_W-1:0]    s_stack_index,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sos_pkg::DATA_W-1:0]   m_popped_value,
    output logic [sos_pkg::STAT_W-1:0]   m_status,
    output logic [sos_pkg::USE_W-1:0]    m_substacks_in_use,
    input  logic                         cfg_we,
    input  logic [sos_pkg::SIZE_W-1:0]   cfg_size,
    output logic [sos_pkg::SIZE_W-1:0]   size,
    output sos_pkg::op_t                 op,
    input  logic [sos_pkg::DATA_W-1:0]   rd_word
);
    import sos_pkg::*;

    typedef enum logic [1:0] {
        S_RUN     = 2'b01,
        S_RECOUNT = 2'b10
    } state_t;

    state_t              state_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [CNT_W-1:0]    in_use_reg, in_use_next;
    logic [SIZE_W-1:0]   fill_reg,   fill_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    quot_reg;
    logic                m_valid_reg;
    logic [DATA_W-1:0]   popped_reg, popped_next;
    stat_t               status_reg, status_next;

    logic [SIZE_W-1:0]   eff_size;
    logic                accept;
    logic                full;
    logic                empty;
    logic                idx_ok;
    logic [PROD_W-1:0]   prod;
    logic [CNT_W-1:0]    end_pos;
    logic [CNT_W-1:0]    top_pos;
    logic                do_push;
    logic                do_remove;
    logic [ADDR_W-1:0]   pos;

    assign eff_size = (size_reg == '0) ? SIZE_W'(1) : size_reg;
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_RUN) && (!m_valid_reg || m_ready);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign idx_ok   = (CNT_W'(s_stack_index) < in_use_reg);
    assign prod     = (PROD_W'(s_stack_index) + PROD_W'(1)) * PROD_W'(eff_size);
    assign end_pos  = (prod > PROD_W'(count_reg)) ? count_reg : CNT_W'(prod);
    assign top_pos  = count_reg - CNT_W'(1);

    always_comb begin
        do_push     = 1'b0;
        do_remove   = 1'b0;
        pos         = count_reg[ADDR_W-1:0];
        status_next = ST_OK;
        unique case (kind_t'(s_kind))
            KIND_PUSH: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_push = 1'b1;
                end
            end
            KIND_POP: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    do_remove = 1'b1;
                    pos       = top_pos[ADDR_W-1:0];
                end
            end
            KIND_POP_AT: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!idx_ok) begin
                    status_next = ST_NO_SUB;
                end else begin
                    do_remove = 1'b1;
                    pos       = ADDR_W'(end_pos - CNT_W'(1));
                end
            end
            KIND_NONE: begin
                status_next = ST_OK;
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb begin
        op.push     = accept && do_push;
        op.remove   = accept && do_remove;
        op.pos      = pos;
        popped_next = do_remove ? rd_word : '0;
    end

    // Incremental substack bookkeeping; every removal drops the top of the store
    always_comb begin
        count_next  = count_reg;
        in_use_next = in_use_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            count_next = count_reg + CNT_W'(1);
            if (empty || (fill_reg >= eff_size)) begin
                in_use_next = in_use_reg + CNT_W'(1);
                fill_next   = SIZE_W'(1);
            end else begin
                fill_next = fill_reg + SIZE_W'(1);
            end
        end else if (do_remove) begin
            count_next = count_reg - CNT_W'(1);
            if (fill_reg <= SIZE_W'(1)) begin
                in_use_next = in_use_reg - CNT_W'(1);
                fill_next   = (in_use_reg == CNT_W'(1)) ? '0 : eff_size;
            end else begin
                fill_next = fill_reg - SIZE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_RUN;
            size_reg    <= SIZE_RESET;
            count_reg   <= '0;
            in_use_reg  <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                // restart the substack recount under the new size
                size_reg  <= cfg_size;
                rem_reg   <= count_reg;
                quot_reg  <= '0;
                state_reg <= S_RECOUNT;
            end else if (state_reg == S_RECOUNT) begin
                if (rem_reg > CNT_W'(eff_size)) begin
                    rem_reg  <= rem_reg - CNT_W'(eff_size);
                    quot_reg <= quot_reg + CNT_W'(1);
                end else begin
                    in_use_reg <= quot_reg + CNT_W'(rem_reg != '0);
                    fill_reg   <= SIZE_W'(rem_reg);
                    state_reg  <= S_RUN;
                end
            end

            if (accept) begin
                count_reg   <= count_next;
                in_use_reg  <= in_use_next;
                fill_reg    <= fill_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    logic [CNT_W-1:0] in_use_out_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_use_out_reg <= in_use_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_popped_value     = popped_reg;
    assign m_status           = status_reg;
    assign m_substacks_in_use = USE_W'(in_use_out_reg);
    assign size               = size_reg;

endmodule

// ----- src/set_of_stacks_with_pop_at_unit.sv -----
// ----------------------------------------------------------------------------
// set_of_stacks_with_pop_at_unit: packed store of substacks with pop-at
// Push, pop and pop-at-substack over a row of word cells that shift down
// by one place to close the gap left by a removal.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  s_        in         s_valid / s_ready       s_kind, s_push_value, s_stack_index
//  m_        out        m_valid / m_ready       m_popped_value, m_status,
//                                               m_substacks_in_use
//  APB       in         psel, penable, pready   paddr, pwrite, pwdata, prdata
//
//  One word is taken per cycle outside a recount while the result register is free
//  or drained in the same cycle; the result shows in the cycle after acceptance.
//  A write of substack_size recounts the substacks by repeated subtraction of the
//  size from the word count, with s_ready low until the recount ends.
//  Reset is synchronous and clears counters and the result valid; the cells
//  need no clearing since only cells below the word count are ever read.
//  A stalled result holds its register and blocks the next word only.
//
module set_of_stacks_with_pop_at_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sos_pkg::KIND_W-1:0]    s_kind,
    input  logic signed [sos_pkg::DATA_W-1:0] s_push_value,
    input  logic [sos_pkg::IDX_W-1:0]     s_stack_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [sos_pkg::DATA_W-1:0] m_popped_value,
    output logic [sos_pkg::STAT_W-1:0]    m_status,
    output logic [sos_pkg::USE_W-1:0]     m_substacks_in_use,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sos_pkg::PADDR_W-1:0]   paddr,
    input  logic [sos_pkg::PDATA_W-1:0]   pwdata,
    output logic [sos_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import sos_pkg::*;

    op_t               op;
    logic [DATA_W-1:0] cell_word [DEPTH];
    logic [DATA_W-1:0] rd_word;
    logic [DATA_W-1:0] popped_word;
    logic [SIZE_W-1:0] size;
    logic              cfg_we;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_we  = psel && penable && pwrite && pready && (reg_sel == REG_SUBSTACK_SIZE);
    assign prdata  = (reg_sel == REG_SUBSTACK_SIZE) ? PDATA_W'(size) : '0;

    sos_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_stack_index      (s_stack_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_popped_value     (popped_word),
        .m_status           (m_status),
        .m_substacks_in_use (m_substacks_in_use),
        .cfg_we             (cfg_we),
        .cfg_size           (pwdata[SIZE_W-1:0]),
        .size               (size),
        .op                 (op),
        .rd_word            (rd_word)
    );

    assign m_popped_value = popped_word;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic [DATA_W-1:0] upper;
            if (i < DEPTH - 1) begin : g_mid
                assign upper = cell_word[i + 1];
            end else begin : g_top
                assign upper = '0;
            end
            sos_cell u_cell (
                .aclk       (aclk),
                .cell_idx   (ADDR_W'(i)),
                .op         (op),
                .push_word  (s_push_value),
                .upper_word (upper),
                .word       (cell_word[i])
            );
        end
    endgenerate

    assign rd_word = cell_word[op.pos];

endmodule

// ----- src/sos_checker.sv -----
// ----------------------------------------------------------------------------
// sos_checker: port-level checks for the set-of-stacks unit
// Watches the handshakes and result codes seen at the top-level ports.
// ----------------------------------------------------------------------------
module sos_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [sos_pkg::DATA_W-1:0]  m_popped_value,
    input  logic [sos_pkg::STAT_W-1:0]  m_status,
    input  logic [sos_pkg::USE_W-1:0]   m_substacks_in_use
);
    import sos_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_popped_value)
            && $stable(m_status) && $stable(m_substacks_in_use))
        else $error("result changed while stalled");

    // a full result register blocks the input side
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted word gave no result");

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY || m_status == ST_FULL || m_status == ST_NO_SUB)
            |-> m_popped_value == '0)
        else $error("flagged result carries a word");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind set_of_stacks_with_pop_at_unit sos_checker u_sos_checker (.*);
